@@ sv/deap_pkg.sv @@
// Shared types and constants for the double-ended heap queue.
`timescale 1ns / 1ps
`default_nettype none
package deap_pkg;

   localparam int STORE_DEPTH = 64;
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int CAPACITY    = STORE_DEPTH - 1;

   typedef logic [IDX_W-1:0] idx_type;

   localparam logic [1:0] ACT_INSERT  = 2'd0;
   localparam logic [1:0] ACT_DEL_MIN = 2'd1;
   localparam logic [1:0] ACT_DEL_MAX = 2'd2;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic [1:0] {
      DEC_NOP,
      DEC_INS,
      DEC_DEL
   } dec_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DECIDE, S_DEL2, S_SIFT, S_SIFT_A, S_SIFT_B, S_PLACE,
      S_PX_A, S_PX_B, S_PX_R, S_PX_C, S_PN_C, S_BUB, S_BUB_C,
      S_FIN1, S_FIN2, S_FIN3
   } state_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_LOAD, CMD_DECIDE, CMD_DEL2, CMD_SIFT, CMD_SIFT_A, CMD_SIFT_B,
      CMD_PLACE, CMD_PX_A, CMD_PX_B, CMD_PX_R, CMD_PX_C, CMD_PN_C, CMD_BUB,
      CMD_BUB_C, CMD_FIN1, CMD_FIN2, CMD_FIN3
   } cmd_type;

   typedef struct packed {
      dec_type dec;
      logic    del_direct;
      logic    c_gt_last;
      logic    has_right;
      logic    pos_max;
      logic    place_read;
      logic    pos_gt2;
      logic    bub_stop;
   } stat_type;

   // half the width of the level holding slot pos (pos >= 1)
   function automatic idx_type level_half(idx_type pos);
      logic [IDX_W:0] p1;
      idx_type        h;
      p1 = {1'b0, pos} + (IDX_W+1)'(1);
      h  = '0;
      for (int b = 1; b <= IDX_W; b++) begin
         if (p1[b]) begin
            h = idx_type'(1) << (b - 1);
         end
      end
      return h;
   endfunction

endpackage
`default_nettype wire

@@ sv/deap_ctrl.sv @@
// Sequencer for the double-ended heap: state register, commands and result valid.
`timescale 1ns / 1ps
`default_nettype none
module deap_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire deap_pkg::stat_type stat,
   output deap_pkg::cmd_type      cmd
);

   deap_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic load_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= deap_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = deap_pkg::CMD_NONE;
      load_out = 1'b0;
      case (state_ff)
         deap_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd      = deap_pkg::CMD_LOAD;
               state_in = deap_pkg::S_DECIDE;
            end
         end
         deap_pkg::S_DECIDE: begin
            cmd = deap_pkg::CMD_DECIDE;
            case (stat.dec)
               deap_pkg::DEC_INS: state_in = deap_pkg::S_PLACE;
               deap_pkg::DEC_DEL: state_in = deap_pkg::S_DEL2;
               default:           state_in = deap_pkg::S_FIN1;
            endcase
         end
         deap_pkg::S_DEL2: begin
            cmd      = deap_pkg::CMD_DEL2;
            state_in = stat.del_direct ? deap_pkg::S_FIN1 : deap_pkg::S_SIFT;
         end
         deap_pkg::S_SIFT: begin
            cmd      = deap_pkg::CMD_SIFT;
            state_in = stat.c_gt_last ? deap_pkg::S_PLACE : deap_pkg::S_SIFT_A;
         end
         deap_pkg::S_SIFT_A: begin
            cmd      = deap_pkg::CMD_SIFT_A;
            state_in = stat.has_right ? deap_pkg::S_SIFT_B : deap_pkg::S_SIFT;
         end
         deap_pkg::S_SIFT_B: begin
            cmd      = deap_pkg::CMD_SIFT_B;
            state_in = deap_pkg::S_SIFT;
         end
         deap_pkg::S_PLACE: begin
            cmd = deap_pkg::CMD_PLACE;
            if (stat.pos_max) begin
               state_in = stat.place_read ? deap_pkg::S_PX_A : deap_pkg::S_PX_R;
            end else begin
               state_in = stat.place_read ? deap_pkg::S_PN_C : deap_pkg::S_BUB;
            end
         end
         deap_pkg::S_PX_A: begin
            cmd      = deap_pkg::CMD_PX_A;
            state_in = stat.has_right ? deap_pkg::S_PX_B : deap_pkg::S_PX_C;
         end
         deap_pkg::S_PX_B: begin
            cmd      = deap_pkg::CMD_PX_B;
            state_in = deap_pkg::S_PX_C;
         end
         deap_pkg::S_PX_R: begin
            cmd      = deap_pkg::CMD_PX_R;
            state_in = deap_pkg::S_PX_C;
         end
         deap_pkg::S_PX_C: begin
            cmd      = deap_pkg::CMD_PX_C;
            state_in = deap_pkg::S_BUB;
         end
         deap_pkg::S_PN_C: begin
            cmd      = deap_pkg::CMD_PN_C;
            state_in = deap_pkg::S_BUB;
         end
         deap_pkg::S_BUB: begin
            cmd      = deap_pkg::CMD_BUB;
            state_in = stat.pos_gt2 ? deap_pkg::S_BUB_C : deap_pkg::S_FIN1;
         end
         deap_pkg::S_BUB_C: begin
            cmd      = deap_pkg::CMD_BUB_C;
            state_in = stat.bub_stop ? deap_pkg::S_FIN1 : deap_pkg::S_BUB;
         end
         deap_pkg::S_FIN1: begin
            cmd      = deap_pkg::CMD_FIN1;
            state_in = deap_pkg::S_FIN2;
         end
         deap_pkg::S_FIN2: begin
            cmd      = deap_pkg::CMD_FIN2;
            state_in = deap_pkg::S_FIN3;
         end
         deap_pkg::S_FIN3: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd      = deap_pkg::CMD_FIN3;
               load_out = 1'b1;
               state_in = deap_pkg::S_IDLE;
            end
         end
         default: state_in = deap_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_stall = (state_ff != deap_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

@@ sv/deap_dp.sv @@
// Datapath for the double-ended heap: key store, position registers, result beat.
`timescale 1ns / 1ps
`default_nettype none
module deap_dp (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire deap_pkg::cmd_type  cmd,
   output deap_pkg::stat_type      stat,
   input  wire logic [1:0]         req_action,
   input  wire logic signed [31:0] req_key_value,
   output logic [1:0]              rsp_status,
   output logic [5:0]              rsp_item_count,
   output logic                    rsp_has_items,
   output logic signed [31:0]      rsp_min_key,
   output logic signed [31:0]      rsp_max_key
);

   localparam int IW = deap_pkg::IDX_W;

   logic signed [31:0] mem [deap_pkg::STORE_DEPTH];

   logic [1:0]         act_ff;
   logic signed [31:0] key_ff, a_ff, rd_ff, mn_ff;
   deap_pkg::idx_type  cnt_ff, last_ff, pos_ff, alt_ff;
   logic               dir_max_ff;
   logic [1:0]         st_ff;
   logic [1:0]         o_status_ff;
   logic [5:0]         o_count_ff;
   logic               o_has_ff;
   logic signed [31:0] o_min_ff, o_max_ff;

   logic               mem_we, mem_re;
   deap_pkg::idx_type  mem_wa, mem_ra;
   logic signed [31:0] mem_wd;

   deap_pkg::idx_type  half, jx, jn, parent;
   logic [IW:0]        p1, sift_c, alt_nx, cx, jn_w, last_x;
   logic [IW+1:0]      three_h;
   logic               pick_right;
   deap_pkg::dec_type  dec;
   logic               is_del;

   always_comb begin
      half    = deap_pkg::level_half(pos_ff);
      p1      = {1'b0, pos_ff} + (IW+1)'(1);
      three_h = ({2'b0, half} << 1) + {2'b0, half};
      last_x  = {1'b0, last_ff};
      sift_c  = {pos_ff, 1'b1};
      alt_nx  = {1'b0, alt_ff} + (IW+1)'(1);
      jx      = pos_ff - half;
      cx      = {jx, 1'b1};
      jn_w    = {1'b0, pos_ff} + {1'b0, half};
      jn      = (jn_w > last_x) ? IW'((jn_w - (IW+1)'(1)) >> 1) : jn_w[IW-1:0];
      parent  = IW'((pos_ff - IW'(1)) >> 1);
      pick_right = dir_max_ff ? (rd_ff > a_ff) : (rd_ff < a_ff);
      is_del  = (act_ff == deap_pkg::ACT_DEL_MIN) || (act_ff == deap_pkg::ACT_DEL_MAX);
      dec     = deap_pkg::DEC_NOP;
      if (act_ff == deap_pkg::ACT_INSERT) begin
         if (cnt_ff != IW'(deap_pkg::CAPACITY) && cnt_ff != '0) begin
            dec = deap_pkg::DEC_INS;
         end
      end else if (is_del) begin
         if (cnt_ff > IW'(2) ||
             (cnt_ff == IW'(2) && act_ff == deap_pkg::ACT_DEL_MIN)) begin
            dec = deap_pkg::DEC_DEL;
         end
      end
      stat.dec        = dec;
      stat.del_direct = (act_ff == deap_pkg::ACT_DEL_MIN) && (last_ff == IW'(1));
      stat.c_gt_last  = sift_c > last_x;
      stat.has_right  = alt_nx <= last_x;
      stat.pos_max    = {1'b0, p1} >= three_h;
      stat.place_read = stat.pos_max ? (cx <= last_x) : (jn >= IW'(2));
      stat.pos_gt2    = pos_ff > IW'(2);
      stat.bub_stop   = dir_max_ff ? (rd_ff >= key_ff) : (rd_ff <= key_ff);
   end

   always_comb begin
      mem_we = 1'b0;
      mem_re = 1'b0;
      mem_wa = pos_ff;
      mem_ra = pos_ff;
      mem_wd = key_ff;
      case (cmd)
         deap_pkg::CMD_DECIDE: begin
            if (act_ff == deap_pkg::ACT_INSERT && cnt_ff == '0) begin
               mem_we = 1'b1;
               mem_wa = IW'(1);
            end
            mem_re = dec == deap_pkg::DEC_DEL;
            mem_ra = cnt_ff;
         end
         deap_pkg::CMD_DEL2: begin
            mem_we = stat.del_direct;
            mem_wa = IW'(1);
            mem_wd = rd_ff;
         end
         deap_pkg::CMD_SIFT: begin
            mem_re = !stat.c_gt_last;
            mem_ra = IW'(sift_c);
         end
         deap_pkg::CMD_SIFT_A: begin
            mem_re = stat.has_right;
            mem_ra = IW'(alt_nx);
            mem_we = !stat.has_right;
            mem_wd = rd_ff;
         end
         deap_pkg::CMD_SIFT_B: begin
            mem_we = 1'b1;
            mem_wd = pick_right ? rd_ff : a_ff;
         end
         deap_pkg::CMD_PLACE: begin
            mem_re = stat.place_read || stat.pos_max;
            if (stat.pos_max) begin
               mem_ra = (cx <= last_x) ? IW'(cx) : jx;
            end else begin
               mem_ra = jn;
            end
         end
         deap_pkg::CMD_PX_A: begin
            mem_re = stat.has_right;
            mem_ra = IW'(alt_nx);
         end
         deap_pkg::CMD_PX_C: begin
            mem_we = key_ff < a_ff;
            mem_wd = a_ff;
         end
         deap_pkg::CMD_PN_C: begin
            mem_we = key_ff > rd_ff;
            mem_wd = rd_ff;
         end
         deap_pkg::CMD_BUB: begin
            mem_re = stat.pos_gt2;
            mem_ra = parent;
            mem_we = !stat.pos_gt2;
         end
         deap_pkg::CMD_BUB_C: begin
            mem_we = 1'b1;
            mem_wd = stat.bub_stop ? key_ff : rd_ff;
         end
         deap_pkg::CMD_FIN1: begin
            mem_re = 1'b1;
            mem_ra = IW'(1);
         end
         deap_pkg::CMD_FIN2: begin
            mem_re = 1'b1;
            mem_ra = IW'(2);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         case (cmd)
            deap_pkg::CMD_DECIDE: begin
               if (act_ff == deap_pkg::ACT_INSERT) begin
                  if (cnt_ff != IW'(deap_pkg::CAPACITY)) begin
                     cnt_ff <= cnt_ff + IW'(1);
                  end
               end else if (is_del) begin
                  if (cnt_ff == IW'(1) ||
                      (cnt_ff == IW'(2) && act_ff == deap_pkg::ACT_DEL_MAX) ||
                      dec == deap_pkg::DEC_DEL) begin
                     cnt_ff <= cnt_ff - IW'(1);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd)
         deap_pkg::CMD_LOAD: begin
            act_ff <= req_action;
            key_ff <= req_key_value;
         end
         deap_pkg::CMD_DECIDE: begin
            st_ff <= deap_pkg::ST_DONE;
            if (act_ff == deap_pkg::ACT_INSERT && cnt_ff == IW'(deap_pkg::CAPACITY)) begin
               st_ff <= deap_pkg::ST_FULL;
            end
            if (is_del && cnt_ff == '0) begin
               st_ff <= deap_pkg::ST_EMPTY;
            end
            if (act_ff == deap_pkg::ACT_INSERT) begin
               pos_ff  <= cnt_ff + IW'(1);
               last_ff <= cnt_ff + IW'(1);
            end else begin
               last_ff <= cnt_ff - IW'(1);
            end
         end
         deap_pkg::CMD_DEL2: begin
            key_ff     <= rd_ff;
            pos_ff     <= (act_ff == deap_pkg::ACT_DEL_MIN) ? IW'(1) : IW'(2);
            dir_max_ff <= act_ff == deap_pkg::ACT_DEL_MAX;
         end
         deap_pkg::CMD_SIFT: begin
            alt_ff <= IW'(sift_c);
         end
         deap_pkg::CMD_SIFT_A: begin
            a_ff <= rd_ff;
            if (!stat.has_right) begin
               pos_ff <= alt_ff;
            end
         end
         deap_pkg::CMD_SIFT_B: begin
            pos_ff <= pick_right ? IW'(alt_nx) : alt_ff;
         end
         deap_pkg::CMD_PLACE: begin
            if (stat.pos_max) begin
               alt_ff <= (cx <= last_x) ? IW'(cx) : jx;
            end else begin
               alt_ff     <= jn;
               dir_max_ff <= 1'b0;
            end
         end
         deap_pkg::CMD_PX_A, deap_pkg::CMD_PX_R: begin
            a_ff <= rd_ff;
         end
         deap_pkg::CMD_PX_B: begin
            if (rd_ff > a_ff) begin
               a_ff   <= rd_ff;
               alt_ff <= IW'(alt_nx);
            end
         end
         deap_pkg::CMD_PX_C: begin
            if (key_ff < a_ff) begin
               pos_ff     <= alt_ff;
               dir_max_ff <= 1'b0;
            end else begin
               dir_max_ff <= 1'b1;
            end
         end
         deap_pkg::CMD_PN_C: begin
            if (key_ff > rd_ff) begin
               pos_ff     <= alt_ff;
               dir_max_ff <= 1'b1;
            end else begin
               dir_max_ff <= 1'b0;
            end
         end
         deap_pkg::CMD_BUB: begin
            alt_ff <= parent;
         end
         deap_pkg::CMD_BUB_C: begin
            if (!stat.bub_stop) begin
               pos_ff <= alt_ff;
            end
         end
         deap_pkg::CMD_FIN2: begin
            mn_ff <= rd_ff;
         end
         deap_pkg::CMD_FIN3: begin
            o_status_ff <= st_ff;
            o_count_ff  <= 6'(cnt_ff);
            o_has_ff    <= cnt_ff != '0;
            o_min_ff    <= (cnt_ff == '0) ? 32'sd0 : mn_ff;
            o_max_ff    <= (cnt_ff == '0) ? 32'sd0 :
                           (cnt_ff == IW'(1)) ? mn_ff : rd_ff;
         end
         default: ;
      endcase
   end

   assign rsp_status     = o_status_ff;
   assign rsp_item_count = o_count_ff;
   assign rsp_has_items  = o_has_ff;
   assign rsp_min_key    = o_min_ff;
   assign rsp_max_key    = o_max_ff;

endmodule
`default_nettype wire

@@ sv/deap_double_ended_priority_queue.sv @@
// Double-ended priority queue (deap) top level: sequencer plus datapath.
// One request at a time; refused or trivial requests go straight to the final states,
// while an insert or a delete first walks the key store one heap level at a time.
// Next request is taken the cycle after the result register loads; a stalled
// result holds the next one in its final state.
// Synchronous reset empties the queue; key store contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module deap_double_ended_priority_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_action,
   input  wire logic signed [31:0] req_key_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [5:0]              rsp_item_count,
   output logic                    rsp_has_items,
   output logic signed [31:0]      rsp_min_key,
   output logic signed [31:0]      rsp_max_key
);

   deap_pkg::cmd_type  cmd;
   deap_pkg::stat_type stat;

   deap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   deap_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_action     (req_action),
      .req_key_value  (req_key_value),
      .rsp_status     (rsp_status),
      .rsp_item_count (rsp_item_count),
      .rsp_has_items  (rsp_has_items),
      .rsp_min_key    (rsp_min_key),
      .rsp_max_key    (rsp_max_key)
   );

endmodule
`default_nettype wire
